FILE: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_REAR  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_REAR   = 2'd2,
    REQ_POP_FRONT  = 2'd3
  } deq_req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } deq_state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic reject;
  } deq_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
  } deq_stat_t;

endpackage

FILE: src/deq_if.sv
// ----------------------------------------------------------------------------
// deq_if
// Request and response channels of the double-ended queue.
// ----------------------------------------------------------------------------
interface deq_req_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pop_value;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

FILE: src/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer that takes a request, has the datapath execute it and holds
// the response until it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  deq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_pop && !stat.empty) begin
          cmd.pop = 1'b1;
        end else if (!stat.is_pop && !stat.full) begin
          cmd.push = 1'b1;
        end else begin
          cmd.reject = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Circular word store with front and rear indices, word count and the
// response registers.
// ----------------------------------------------------------------------------
module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  deq_cmd_t                   cmd,
  output deq_stat_t                  stat,
  input  logic [REQ_W-1:0]           req_type,
  input  logic signed [WORD_W-1:0]   push_value,
  output logic signed [WORD_W-1:0]   pop_value,
  output logic [STATUS_W-1:0]        status,
  output logic [OCC_W-1:0]           occupancy
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  logic signed [WORD_W-1:0] mem [DEPTH];

  deq_req_t                 req_r;
  logic signed [WORD_W-1:0] value_r;
  logic signed [WORD_W-1:0] rd_r;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [IDX_W-1:0]         rear_r, rear_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     pop_ok_r;
  deq_status_t              status_r;

  logic             is_front;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    is_front    = (req_r == REQ_PUSH_FRONT) || (req_r == REQ_POP_FRONT);
    wr_addr     = is_front ? idx_prev(front_r) : rear_r;
    rd_addr     = is_front ? front_r : idx_prev(rear_r);
    stat.is_pop = (req_r == REQ_POP_REAR) || (req_r == REQ_POP_FRONT);
    stat.empty  = (count_r == '0);
    stat.full   = (count_r == FULL_CNT);
  end

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
      if (is_front) begin
        front_nxt = idx_prev(front_r);
      end else begin
        rear_nxt = idx_next(rear_r);
      end
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
      if (is_front) begin
        front_nxt = idx_next(front_r);
      end else begin
        rear_nxt = idx_prev(rear_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      count_r  <= '0;
      pop_ok_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
      if (cmd.push || cmd.pop || cmd.reject) begin
        pop_ok_r <= cmd.pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= deq_req_t'(req_type);
      value_r <= push_value;
    end
    if (cmd.push || cmd.pop) begin
      status_r <= ST_OK;
    end else if (cmd.reject) begin
      status_r <= stat.is_pop ? ST_EMPTY : ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= value_r;
    end
    if (cmd.pop) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign pop_value = pop_ok_r ? rd_r : '0;
  assign status    = status_r;
  assign occupancy = OCC_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("Word count exceeds the store depth.");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> count_r == $past(count_r) + 1'b1)
    else $error("Accepted push did not raise the word count by one.");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - 1'b1)
    else $error("Accepted pop did not lower the word count by one.");

  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reject |=> $stable(count_r) && $stable(front_r) && $stable(rear_r))
    else $error("Rejected request changed the queue state.");

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.push, cmd.pop, cmd.reject}))
    else $error("More than one datapath command in a cycle.");

endmodule

FILE: src/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid / ready      req_type[1:0], push_value[31:0]
//  out_ch   out  valid / ready      pop_value[31:0], status[1:0], occupancy[4:0]
//
//  A request passes through accept, execute in the store, and response.
//  The store's single registered read port sets the execute cycle.
//  Reset clears the indices and the word count; the store is not cleared.
//  A new request is taken only after the previous response is taken.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_req_if.sink   in_ch,
  deq_rsp_if.source out_ch
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (in_ch.req_type),
    .push_value (in_ch.push_value),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status),
    .occupancy  (out_ch.occupancy)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the double-ended queue. A shadow copy of the
// circular store predicts the popped word, status and occupancy of every
// request, and each response is compared with the oldest prediction. The
// sender and the receiver idle at random, and the receiver once holds off
// long enough to back up the request channel.
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  localparam int QUEUE_DEPTH = DEPTH_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_REQS = 1625;

  typedef struct {
    logic signed [WORD_W-1:0] pop_value;
    deq_status_t              status;
    logic [OCC_W-1:0]         occupancy;
  } deq_result_t;

  class deque_shadow;
    logic [WORD_W-1:0] words [QUEUE_DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       count;
    deq_result_t       pending_results [$];
    int                errors;

    function new();
      head   = 0;
      tail   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function void note_request(deq_req_t kind, logic [WORD_W-1:0] value);
      deq_result_t r;
      r.pop_value = '0;
      r.status    = ST_OK;
      case (kind)
        REQ_PUSH_REAR: begin
          if (count == QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            words[tail] = value;
            tail = (tail + 1) % QUEUE_DEPTH;
            count++;
          end
        end
        REQ_PUSH_FRONT: begin
          if (count == QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            words[head] = value;
            count++;
          end
        end
        REQ_POP_REAR: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            tail = (tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            r.pop_value = words[tail];
            count--;
          end
        end
        default: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.pop_value = words[head];
            head = (head + 1) % QUEUE_DEPTH;
            count--;
          end
        end
      endcase
      r.occupancy = OCC_W'(count);
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [WORD_W-1:0] pop_value, logic [STATUS_W-1:0] status,
                                 logic [OCC_W-1:0] occupancy);
      deq_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: response with no request waiting", $time);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (pop_value !== want.pop_value) begin
        $display("%0t: pop_value expected %0d, got %0d", $time, want.pop_value,
                 $signed(pop_value));
        errors++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        errors++;
      end
      if (occupancy !== want.occupancy) begin
        $display("%0t: occupancy expected %0d, got %0d", $time, want.occupancy, occupancy);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  deq_req_if in_ch ();
  deq_rsp_if out_ch ();

  double_ended_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_shadow shadow = new();
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] extreme_word(int k);
    case (k % 4)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_request(input deq_req_t kind, input logic [WORD_W-1:0] value);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= kind;
    in_ch.push_value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        shadow.note_request(deq_req_t'(in_ch.req_type), in_ch.push_value);
      end
      if (out_ch.valid && out_ch.ready) begin
        shadow.check_response(out_ch.pop_value, out_ch.status, out_ch.occupancy);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // The long hold-off backs up the request channel while the sender keeps offering.
  initial begin
    int taken;
    int stall;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 64 == 0) begin
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      stall = recv_calm ? 0 : $urandom_range(0, 9);
      if (taken == 300) begin
        stall = 250;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int       i;
    int       push_pct;
    deq_req_t kind;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_PUSH_REAR;
    in_ch.push_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_POP_REAR, 32'h0000_0000);
    send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      send_request((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_REAR,
                   (i < 8) ? extreme_word(i / 2 + i) : $urandom);
    end
    send_request(REQ_PUSH_REAR, 32'h5555_5555);
    send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_POP_REAR, 32'h0000_0000);
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_POP_REAR, 32'h0000_0000);

    push_pct = 50;
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        send_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct) begin
        kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
      end else begin
        kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR;
      end
      send_request(kind, ($urandom_range(0, 7) == 0) ? extreme_word($urandom_range(0, 3))
                                                      : $urandom);
    end
    in_ch.valid <= 1'b0;

    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.errors == 0 && shadow.outstanding() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
